### hdl/rdce_pkg.sv
`timescale 1ns / 1ps
package rdce_pkg;
    typedef enum logic [2:0] {
        OP_LINE    = 3'd0,
        OP_OUTLINE = 3'd1,
        OP_FILL    = 3'd2,
        OP_COPY    = 3'd3,
        OP_HMIRROR = 3'd4,
        OP_VMIRROR = 3'd5,
        OP_INVERT  = 3'd6,
        OP_READ    = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE_INIT,
        ST_LINE,
        ST_RECT,
        ST_COPY_RD,
        ST_COPY_WAIT,
        ST_COPY_WR,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_DONE
    } state_t;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;
    localparam logic [7:0] PIX_MAX    = 8'd255;
endpackage

### hdl/rdce_fb_mem.sv
`timescale 1ns / 1ps
module rdce_fb_mem #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/raster_draw_and_copy_engine.sv
`timescale 1ns / 1ps
// channel | signals                                    | beat when
// in      | in_valid/in_ready, opcode..color           | in_valid && in_ready
// out     | out_valid/out_ready, pixel_value, clipped  | out_valid && out_ready
// cfg     | cfg_we, cfg_index, cfg_data                | cfg_we
// At most one pixel access per cycle through a framebuffer with one write and
// one read port and one shared Bresenham step unit: line a setup state, then one
// pixel per step per segment (outline four segments); fill one pixel per step;
// copy ST_COPY_RD/WAIT/WR per pixel, read ST_READ_WAIT/DONE; ST_DONE then raises out_valid.
// After reset a clearing pass zeroes all 2**AW framebuffer words (65536 at the
// default size), one pixel a cycle; no command is taken meanwhile.
// A result waits in the output register; the next command enters after it is taken.
module raster_draw_and_copy_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] first_x,
    input  logic [7:0] first_y,
    input  logic [7:0] second_x,
    input  logic [7:0] second_y,
    input  logic [7:0] target_x,
    input  logic [7:0] target_y,
    input  logic [7:0] color,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_value,
    output logic       clipped,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [8:0] cfg_data
);
    import rdce_pkg::*;

    // coordinates are 8 bits, so columns or rows past 256 are never addressed
    localparam int XW = (MAX_WIDTH > 256) ? 8 : $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 256) ? 8 : $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CW = 10; // signed coordinate
    localparam int EW = 11; // Bresenham error

    logic [8:0] width_reg, height_reg;
    state_t state_reg, state_next;
    logic [AW:0] clr_reg;
    op_t op_reg;
    logic [7:0] fx_reg, fy_reg, sx_reg, sy_reg, tx_reg, ty_reg, col_reg;
    logic [7:0] dx_reg, dy_reg;
    logic [7:0] i_reg, j_reg;
    logic [1:0] seg_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, ex_reg, ey_reg;
    logic signed [EW-1:0] err_reg, ldx_reg, ldy_reg;
    logic lsx_reg, lsy_reg;
    logic clip_reg;
    logic out_valid_reg;
    logic [7:0] pv_reg;
    logic src_ok_reg;
    logic accept;

    assign accept = in_valid && in_ready;

    // effective size
    logic [12:0] eff_w, eff_h;
    assign eff_w = (13'(width_reg) < 13'(MAX_WIDTH)) ? 13'(width_reg) : 13'(MAX_WIDTH);
    assign eff_h = (13'(height_reg) < 13'(MAX_HEIGHT)) ? 13'(height_reg) : 13'(MAX_HEIGHT);

    function automatic logic in_img(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                    input logic [12:0] w, input logic [12:0] h);
        in_img = !x[CW-1] && !y[CW-1] && (13'(x) < w) && (13'(y) < h);
    endfunction

    // shared address / access unit
    logic signed [CW-1:0] ax, ay;
    logic acc_in;
    assign acc_in = in_img(ax, ay, eff_w, eff_h);

    logic mem_we;
    logic [AW-1:0] mem_addr_w, mem_addr_r;
    logic [7:0] mem_wd, mem_rd;

    rdce_fb_mem #(.AW(AW)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_addr_w),
        .wdata(mem_wd),
        .raddr(mem_addr_r),
        .rdata(mem_rd)
    );

    // copy geometry: outer index i, inner j
    logic vm;
    logic [7:0] outer_lim, inner_lim;
    logic signed [CW-1:0] csx, csy, cdx, cdy;
    assign vm = (op_reg == OP_VMIRROR);
    assign outer_lim = vm ? dy_reg : dx_reg;
    assign inner_lim = vm ? dx_reg : dy_reg;
    always_comb
    begin
        csx = vm ? CW'(fx_reg) + CW'(j_reg) : CW'(fx_reg) + CW'(i_reg);
        csy = vm ? CW'(fy_reg) + CW'(i_reg) : CW'(fy_reg) + CW'(j_reg);
        case (op_reg)
            OP_HMIRROR:
            begin
                cdx = CW'(tx_reg) + CW'(dx_reg) - CW'(i_reg);
                cdy = CW'(ty_reg) + CW'(j_reg);
            end
            OP_VMIRROR:
            begin
                cdx = CW'(tx_reg) + CW'(j_reg);
                cdy = CW'(ty_reg) + CW'(dy_reg) - CW'(i_reg);
            end
            default:
            begin
                cdx = CW'(tx_reg) + CW'(i_reg);
                cdy = CW'(ty_reg) + CW'(j_reg);
            end
        endcase
    end

    logic last_inner, last_outer;
    assign last_inner = (j_reg == inner_lim);
    assign last_outer = (i_reg == outer_lim);

    // fill corners
    logic [7:0] x0f, y0f;
    assign x0f = (fx_reg < sx_reg) ? fx_reg : sx_reg;
    assign y0f = (fy_reg < sy_reg) ? fy_reg : sy_reg;

    // segment endpoints for line / outline
    logic [7:0] sgx0, sgy0, sgx1, sgy1;
    always_comb
    begin
        sgx0 = fx_reg; sgy0 = fy_reg; sgx1 = sx_reg; sgy1 = sy_reg;
        if (op_reg == OP_OUTLINE)
        begin
            case (seg_reg)
                2'd0: begin sgx0 = fx_reg; sgy0 = fy_reg; sgx1 = sx_reg; sgy1 = fy_reg; end
                2'd1: begin sgx0 = fx_reg; sgy0 = fy_reg; sgx1 = fx_reg; sgy1 = sy_reg; end
                2'd2: begin sgx0 = sx_reg; sgy0 = sy_reg; sgx1 = sx_reg; sgy1 = fy_reg; end
                default: begin sgx0 = sx_reg; sgy0 = sy_reg; sgx1 = fx_reg; sgy1 = sy_reg; end
            endcase
        end
    end

    // Bresenham step
    logic line_end;
    logic signed [EW-1:0] e2;
    logic stx, sty;
    assign line_end = (cx_reg == ex_reg) && (cy_reg == ey_reg);
    assign e2 = err_reg <<< 1;
    assign stx = (e2 >= ldy_reg);
    assign sty = (e2 <= ldx_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_reg == (AW+1)'(2**AW - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    unique case (op_t'(opcode))
                        OP_LINE, OP_OUTLINE: state_next = ST_LINE_INIT;
                        OP_FILL:             state_next = ST_RECT;
                        OP_READ:             state_next = ST_READ_WAIT;
                        default:             state_next = ST_COPY_RD;
                    endcase
                end
            ST_LINE_INIT: state_next = ST_LINE;
            ST_LINE:
                if (line_end)
                    state_next = (op_reg == OP_OUTLINE && seg_reg != 2'd3) ? ST_LINE_INIT
                                                                           : ST_DONE;
            ST_RECT:      if (last_inner && last_outer) state_next = ST_DONE;
            ST_COPY_RD:   state_next = ST_COPY_WAIT;
            ST_COPY_WAIT: state_next = ST_COPY_WR;
            ST_COPY_WR:   state_next = (last_inner && last_outer) ? ST_DONE : ST_COPY_RD;
            ST_READ_WAIT: state_next = ST_READ_DONE;
            ST_READ_DONE: state_next = ST_DONE;
            ST_DONE:      if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: one access per cycle
    always_comb
    begin
        ax = cx_reg;
        ay = cy_reg;
        mem_we = 1'b0;
        mem_wd = col_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ax = '0; ay = '0;
                mem_we = 1'b1;
                mem_wd = '0;
            end
            ST_LINE:
            begin
                mem_we = acc_in;
            end
            ST_RECT:
            begin
                ax = CW'(x0f) + CW'(i_reg);
                ay = CW'(y0f) + CW'(j_reg);
                mem_we = acc_in;
            end
            // source address held through the wait so the read data stays put
            ST_COPY_RD, ST_COPY_WAIT:
            begin
                ax = csx; ay = csy;
            end
            ST_COPY_WR:
            begin
                ax = cdx; ay = cdy;
                mem_we = acc_in && src_ok_reg;
                mem_wd = (op_reg == OP_INVERT) ? PIX_MAX - mem_rd : mem_rd;
            end
            ST_READ_WAIT:
            begin
                ax = CW'(fx_reg); ay = CW'(fy_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign mem_addr_r = (state_reg == ST_IDLE) ? {first_y[YW-1:0] & YW'({8{1'b1}}),
                                                  first_x[XW-1:0] & XW'({8{1'b1}})}
                                               : {ay[YW-1:0], ax[XW-1:0]};
    assign mem_addr_w = (state_reg == ST_CLEAR) ? clr_reg[AW-1:0]
                                                : {ay[YW-1:0], ax[XW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            out_valid_reg <= 1'b0;
            clip_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH) width_reg <= cfg_data;
                else height_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (accept) clip_reg <= 1'b0;
            if ((state_reg == ST_LINE || state_reg == ST_RECT || state_reg == ST_COPY_RD ||
                 state_reg == ST_READ_WAIT) && !acc_in)
                clip_reg <= 1'b1;
            if (state_reg == ST_COPY_WR && src_ok_reg && !acc_in) clip_reg <= 1'b1;
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(opcode);
            fx_reg  <= first_x;  fy_reg <= first_y;
            sx_reg  <= second_x; sy_reg <= second_y;
            tx_reg  <= target_x; ty_reg <= target_y;
            col_reg <= color;
            dx_reg  <= (first_x > second_x) ? first_x - second_x : second_x - first_x;
            dy_reg  <= (first_y > second_y) ? first_y - second_y : second_y - first_y;
            i_reg   <= '0;
            j_reg   <= '0;
            seg_reg <= '0;
            pv_reg  <= '0;
        end
        if (state_reg == ST_LINE_INIT)
        begin
            cx_reg  <= CW'(sgx0); cy_reg <= CW'(sgy0);
            ex_reg  <= CW'(sgx1); ey_reg <= CW'(sgy1);
            ldx_reg <= (sgx0 > sgx1) ? EW'(sgx0 - sgx1) : EW'(sgx1 - sgx0);
            ldy_reg <= -((sgy0 > sgy1) ? EW'(sgy0 - sgy1) : EW'(sgy1 - sgy0));
            err_reg <= ((sgx0 > sgx1) ? EW'(sgx0 - sgx1) : EW'(sgx1 - sgx0))
                     - ((sgy0 > sgy1) ? EW'(sgy0 - sgy1) : EW'(sgy1 - sgy0));
            lsx_reg <= (sgx0 < sgx1);
            lsy_reg <= (sgy0 < sgy1);
        end
        if (state_reg == ST_LINE)
        begin
            if (line_end)
                seg_reg <= seg_reg + 1'b1;
            else
            begin
                err_reg <= err_reg + (stx ? ldy_reg : EW'(0)) + (sty ? ldx_reg : EW'(0));
                if (stx) cx_reg <= lsx_reg ? cx_reg + 1'b1 : cx_reg - 1'b1;
                if (sty) cy_reg <= lsy_reg ? cy_reg + 1'b1 : cy_reg - 1'b1;
            end
        end
        if (state_reg == ST_RECT || state_reg == ST_COPY_WR)
        begin
            if (last_inner)
            begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end
            else
                j_reg <= j_reg + 1'b1;
        end
        if (state_reg == ST_COPY_RD) src_ok_reg <= acc_in;
        if (state_reg == ST_READ_WAIT) src_ok_reg <= acc_in;
        if (state_reg == ST_READ_DONE) pv_reg <= src_ok_reg ? mem_rd : 8'd0;
    end

    assign in_ready    = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign pixel_value = pv_reg;
    assign clipped     = clip_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid)
        else $error("result during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(pixel_value) && $stable(clipped))
        else $error("result dropped");
endmodule

### tb/raster_draw_and_copy_engine_checker.sv
`timescale 1ns / 1ps
module raster_draw_and_copy_engine_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] first_x,
    input  logic [7:0] first_y,
    input  logic [7:0] second_x,
    input  logic [7:0] second_y,
    input  logic [7:0] target_x,
    input  logic [7:0] target_y,
    input  logic [7:0] color,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] pixel_value,
    input  logic       clipped,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [8:0] cfg_data,
    output int         errors,
    output int         pending
);
    import rdce_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       clip;
    } pixel_result_t;

    logic [7:0]    frame [0:65535];
    int            width_px, height_px;
    logic          clip_seen;
    pixel_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic bit on_screen(int x, int y);
        return x >= 0 && y >= 0 && x < width_px && y < height_px;
    endfunction

    function automatic void plot(int x, int y, logic [7:0] v);
        if (!on_screen(x, y))
            clip_seen = 1'b1;
        else
            frame[y * 256 + x] = v;
    endfunction

    function automatic void move_pixel(int sx, int sy, int dx, int dy, bit invert);
        logic [7:0] v;
        if (!on_screen(sx, sy))
        begin
            clip_seen = 1'b1;
            return;
        end
        v = frame[sy * 256 + sx];
        plot(dx, dy, invert ? PIX_MAX - v : v);
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1, logic [7:0] c);
        int ax, ay, stx, sty, err, e2;
        ax = x0 > x1 ? x0 - x1 : x1 - x0;
        ay = -(y0 > y1 ? y0 - y1 : y1 - y0);
        stx = x0 < x1 ? 1 : -1;
        sty = y0 < y1 ? 1 : -1;
        err = ax + ay;
        forever
        begin
            plot(x0, y0, c);
            if (x0 == x1 && y0 == y1)
                break;
            e2 = 2 * err;
            if (e2 >= ay)
            begin
                err += ay;
                x0 += stx;
            end
            if (e2 <= ax)
            begin
                err += ax;
                y0 += sty;
            end
        end
    endfunction

    function automatic pixel_result_t run_command(op_t op, int fx, int fy, int sx, int sy,
                                                  int tx, int ty, logic [7:0] c);
        int w, h;
        pixel_result_t r;
        w = fx > sx ? fx - sx : sx - fx;
        h = fy > sy ? fy - sy : sy - fy;
        clip_seen = 1'b0;
        r.value = 8'd0;
        case (op)
            OP_LINE: trace_line(fx, fy, sx, sy, c);
            OP_OUTLINE:
            begin
                trace_line(fx, fy, sx, fy, c);
                trace_line(fx, fy, fx, sy, c);
                trace_line(sx, sy, sx, fy, c);
                trace_line(sx, sy, fx, sy, c);
            end
            OP_FILL:
                for (int i = (fx < sx ? fx : sx); i <= (fx < sx ? sx : fx); i++)
                    for (int j = (fy < sy ? fy : sy); j <= (fy < sy ? sy : fy); j++)
                        plot(i, j, c);
            OP_COPY, OP_INVERT:
                for (int i = 0; i <= w; i++)
                    for (int j = 0; j <= h; j++)
                        move_pixel(fx + i, fy + j, tx + i, ty + j, op == OP_INVERT);
            OP_HMIRROR:
                for (int i = 0; i <= w; i++)
                    for (int j = 0; j <= h; j++)
                        move_pixel(fx + i, fy + j, tx + w - i, ty + j, 1'b0);
            OP_VMIRROR:
                for (int i = 0; i <= h; i++)
                    for (int j = 0; j <= w; j++)
                        move_pixel(fx + j, fy + i, tx + j, ty + h - i, 1'b0);
            default:
                if (on_screen(fx, fy))
                    r.value = frame[fy * 256 + fx];
                else
                    clip_seen = 1'b1;
        endcase
        r.clip = clip_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t exp_r;
        if (!rst_n)
        begin
            errors = 0;
            width_px = 256;
            height_px = 256;
            for (int k = 0; k < 65536; k++)
                frame[k] = 8'd0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_px = cfg_data > 256 ? 256 : cfg_data;
                else
                    height_px = cfg_data > 256 ? 256 : cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat value=%0d clipped=%0b",
                             $time, pixel_value, clipped);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (pixel_value !== exp_r.value)
                    begin
                        errors++;
                        $display("%0t: pixel_value expected %0d actual %0d",
                                 $time, exp_r.value, pixel_value);
                    end
                    if (clipped !== exp_r.clip)
                    begin
                        errors++;
                        $display("%0t: clipped expected %0b actual %0b",
                                 $time, exp_r.clip, clipped);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(run_command(op_t'(opcode), first_x, first_y,
                    second_x, second_y, target_x, target_y, color));
        end
    end
endmodule

### tb/raster_draw_and_copy_engine_test.sv
`timescale 1ns / 1ps
module raster_draw_and_copy_engine_test;
    import rdce_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] opcode = 3'd0;
    logic [7:0] first_x = 8'd0, first_y = 8'd0, second_x = 8'd0, second_y = 8'd0;
    logic [7:0] target_x = 8'd0, target_y = 8'd0, color = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] pixel_value;
    logic       clipped;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = CFG_WIDTH;
    logic [8:0] cfg_data = 9'd0;
    int         errors, pending;
    int         send_idle_pct = 0, recv_idle_pct = 0;
    int         hold_off_cycles = 0;

    always #10 clk = ~clk;

    raster_draw_and_copy_engine u_dut (.*);

    raster_draw_and_copy_engine_checker u_checker (.*);

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up after a beat until an idle cycle or a drain drops it
    task automatic send_command(op_t op, logic [7:0] fx, logic [7:0] fy, logic [7:0] sx,
                                logic [7:0] sy, logic [7:0] tx, logic [7:0] ty,
                                logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        first_x <= fx;
        first_y <= fy;
        second_x <= sx;
        second_y <= sy;
        target_x <= tx;
        target_y <= ty;
        color <= c;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly small regions near a corner, some full-range coordinates
    function automatic logic [7:0] coord(int spread);
        return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(spread));
    endfunction

    task automatic random_commands(int count, int spread);
        logic [7:0] fx, fy;
        op_t op;
        for (int n = 0; n < count; n++)
        begin
            fx = coord(spread);
            fy = coord(spread);
            op = op_t'($urandom_range(7));
            if (op == OP_FILL || op == OP_COPY || op == OP_INVERT
                || op == OP_HMIRROR || op == OP_VMIRROR)
                send_command(op, fx, fy, fx + 8'($urandom_range(12)) - 8'd6,
                             fy + 8'($urandom_range(12)) - 8'd6, coord(spread),
                             coord(spread), 8'($urandom));
            else
                send_command(op, fx, fy, coord(spread), coord(spread), 8'($urandom),
                             8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode, extremes, clipping
        send_command(OP_FILL, 8'd2, 8'd2, 8'd9, 8'd6, 8'd0, 8'd0, 8'd200);
        send_command(OP_READ, 8'd5, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_LINE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255);
        send_command(OP_LINE, 8'd30, 8'd3, 8'd20, 8'd40, 8'd0, 8'd0, 8'd17);
        send_command(OP_OUTLINE, 8'd40, 8'd40, 8'd30, 8'd50, 8'd0, 8'd0, 8'd99);
        send_command(OP_FILL, 8'd60, 8'd70, 8'd60, 8'd61, 8'd0, 8'd0, 8'd1);
        send_command(OP_COPY, 8'd2, 8'd2, 8'd9, 8'd6, 8'd5, 8'd4, 8'd0);
        send_command(OP_HMIRROR, 8'd0, 8'd0, 8'd10, 8'd10, 8'd100, 8'd100, 8'd0);
        send_command(OP_VMIRROR, 8'd20, 8'd3, 8'd30, 8'd12, 8'd22, 8'd5, 8'd0);
        send_command(OP_INVERT, 8'd0, 8'd0, 8'd8, 8'd8, 8'd250, 8'd250, 8'd0);
        send_command(OP_READ, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_READ, 8'd102, 8'd101, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        drain();

        write_reg(CFG_WIDTH, 9'd1);
        write_reg(CFG_HEIGHT, 9'd1);
        send_command(OP_LINE, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd77);
        send_command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_READ, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        drain();
        write_reg(CFG_WIDTH, 9'd0);
        write_reg(CFG_HEIGHT, 9'd511);
        send_command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_FILL, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd5);
        drain();

        // random, small image first
        write_reg(CFG_WIDTH, 9'd24);
        write_reg(CFG_HEIGHT, 9'd17);
        send_idle_pct = 25;
        recv_idle_pct = 78;
        random_commands(150, 30);

        // long receiver stall with the sender still pushing
        hold_off_cycles = 400;
        random_commands(10, 20);
        drain();

        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd100);
        send_idle_pct = 78;
        recv_idle_pct = 25;
        random_commands(200, 40);
        drain();

        write_reg(CFG_WIDTH, 9'd300);
        write_reg(CFG_HEIGHT, 9'd256);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_commands(200, 40);

        drain();
        if (errors == 0)
            $display("raster_draw_and_copy_engine_test: done, clean");
        else
            $display("raster_draw_and_copy_engine_test: done, errors");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("raster_draw_and_copy_engine_test: done, errors");
        $finish;
    end
endmodule

### sim.f
hdl/rdce_pkg.sv
hdl/rdce_fb_mem.sv
hdl/raster_draw_and_copy_engine.sv
tb/raster_draw_and_copy_engine_checker.sv
tb/raster_draw_and_copy_engine_test.sv
